### src/assert_macros.svh
// Assertion helpers for the RTL of the 4D box downsampler.
// Self-contained; no other file needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define VBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge, reset included.
`define VBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/vbd_pkg.sv
// Package of the 4D box downsampler: sizes, register indexes, queue entry type, size clamp.
// No dependencies.
`default_nettype none

package vbd_pkg;

    localparam int SUM_DEPTH  = 65536;
    localparam int MAX_DIM    = 512;
    localparam int ADDR_W     = $clog2(SUM_DEPTH);
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CFG_W      = 10;
    localparam int IDX_W      = 2;
    localparam int VOX_W      = 8;
    localparam int SUM_W      = 12;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_W-1:0] SIZE_X_RST = CFG_W'(64);
    localparam logic [CFG_W-1:0] SIZE_Y_RST = CFG_W'(64);
    localparam logic [CFG_W-1:0] SIZE_Z_RST = CFG_W'(32);

    typedef enum logic [IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } t_reg_idx;

    // One accumulate job handed from front to back.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [VOX_W-1:0]  voxel;
        logic              first;
        logic              last;
        logic              frame_done;
    } t_job;

    // Clamp a size register to [2, MAX_DIM].
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v < CFG_W'(2)) begin
            r = CFG_W'(2);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/vbd_intf.sv
// Handshake channels of the 4D box downsampler: voxel in, result out, config.
// Depends on vbd_pkg.
`default_nettype none

interface vbd_voxel_if;
    logic                       valid;
    logic                       ready;
    logic [vbd_pkg::VOX_W-1:0]  voxel;
    modport source (output valid, output voxel, input ready);
    modport sink   (input valid, input voxel, output ready);
endinterface

interface vbd_result_if;
    logic                       valid;
    logic                       ready;
    logic [vbd_pkg::VOX_W-1:0]  average;
    logic                       frame_done;
    modport source (output valid, output average, output frame_done, input ready);
    modport sink   (input valid, input average, input frame_done, output ready);
endinterface

interface vbd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [vbd_pkg::IDX_W-1:0]  index;
    logic [vbd_pkg::CFG_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/vbd_front.sv
// Front end: size registers, raster position, group classification and the
// two-stage address pipeline. Depends on vbd_pkg and vbd_intf.
`default_nettype none

module vbd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    vbd_voxel_if.sink          i_voxel,
    vbd_cfg_if.sink            i_cfg,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output vbd_pkg::t_job      o_q_job
);

    localparam int DW  = vbd_pkg::DIM_W;
    localparam int CW  = vbd_pkg::CFG_W;
    localparam int AW  = vbd_pkg::ADDR_W;
    localparam int PW1 = 2 * DW;
    localparam int PW2 = AW + DW;

    // configuration
    logic [CW-1:0] r_size_x, r_size_y, r_size_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= vbd_pkg::SIZE_X_RST;
            r_size_y <= vbd_pkg::SIZE_Y_RST;
            r_size_z <= vbd_pkg::SIZE_Z_RST;
        end else if (i_cfg.valid) begin
            unique case (vbd_pkg::t_reg_idx'(i_cfg.index))
                vbd_pkg::REG_SIZE_X: r_size_x <= i_cfg.data;
                vbd_pkg::REG_SIZE_Y: r_size_y <= i_cfg.data;
                vbd_pkg::REG_SIZE_Z: r_size_z <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid, r_s2_valid;
    logic en;
    logic accept;

    assign en            = !r_s2_valid || !i_q_full;
    assign i_voxel.ready = en;
    assign accept        = i_voxel.valid && en;

    // stage 0: classify against current position
    logic [DW-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic          r_time_odd;
    logic [DW-1:0] n_pos_x, n_pos_y, n_pos_z;
    logic          n_time_odd;

    logic [CW-1:0] sx, sy, sz;
    logic [DW-1:0] hx, hy, hz;
    logic [CW-1:0] ex, ey, ez;
    logic [CW-1:0] px, py, pz;
    logic          keep, first, last, frame_done;
    logic          wrap_x, wrap_y, wrap_z;

    always_comb begin
        sx = vbd_pkg::eff_size(r_size_x);
        sy = vbd_pkg::eff_size(r_size_y);
        sz = vbd_pkg::eff_size(r_size_z);
        hx = sx[DW:1];
        hy = sy[DW:1];
        hz = sz[DW:1];
        ex = {hx, 1'b0};
        ey = {hy, 1'b0};
        ez = {hz, 1'b0};
        px = {1'b0, r_pos_x};
        py = {1'b0, r_pos_y};
        pz = {1'b0, r_pos_z};

        keep  = (px < ex) && (py < ey) && (pz < ez);
        first = !(r_pos_x[0] || r_pos_y[0] || r_pos_z[0]) && !r_time_odd;
        last  = r_pos_x[0] && r_pos_y[0] && r_pos_z[0] && r_time_odd;
        frame_done = (px == ex - CW'(1)) && (py == ey - CW'(1)) && (pz == ez - CW'(1));

        wrap_x = (px + CW'(1)) >= sx;
        wrap_y = (py + CW'(1)) >= sy;
        wrap_z = (pz + CW'(1)) >= sz;

        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_pos_z    = r_pos_z;
        n_time_odd = r_time_odd;
        if (wrap_x) begin
            n_pos_x = '0;
            if (wrap_y) begin
                n_pos_y = '0;
                if (wrap_z) begin
                    n_pos_z    = '0;
                    n_time_odd = !r_time_odd;
                end else begin
                    n_pos_z = r_pos_z + DW'(1);
                end
            end else begin
                n_pos_y = r_pos_y + DW'(1);
            end
        end else begin
            n_pos_x = r_pos_x + DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_pos_z    <= '0;
            r_time_odd <= 1'b0;
        end else if (accept) begin
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_pos_z    <= n_pos_z;
            r_time_odd <= n_time_odd;
        end
    end

    // stage 1: slice/row index = (z/2)*hy + y/2
    logic [DW-2:0]                 r_s1_xh, r_s1_yh, r_s1_zh;
    logic [DW-1:0]                 r_s1_hx, r_s1_hy;
    logic [vbd_pkg::VOX_W-1:0]     r_s1_voxel;
    logic                          r_s1_first, r_s1_last, r_s1_fd;
    logic [PW1-1:0]                s1_row;

    assign s1_row = PW1'(r_s1_zh) * PW1'(r_s1_hy) + PW1'(r_s1_yh);

    // stage 2: address = row*hx + x/2, wrapped to the store depth
    logic [AW-1:0]                 r_s2_row;
    logic [DW-2:0]                 r_s2_xh;
    logic [DW-1:0]                 r_s2_hx;
    logic [vbd_pkg::VOX_W-1:0]     r_s2_voxel;
    logic                          r_s2_first, r_s2_last, r_s2_fd;
    logic [PW2-1:0]                s2_addr;

    assign s2_addr = PW2'(r_s2_row) * PW2'(r_s2_hx) + PW2'(r_s2_xh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept && keep;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_xh    <= r_pos_x[DW-1:1];
            r_s1_yh    <= r_pos_y[DW-1:1];
            r_s1_zh    <= r_pos_z[DW-1:1];
            r_s1_hx    <= hx;
            r_s1_hy    <= hy;
            r_s1_voxel <= i_voxel.voxel;
            r_s1_first <= first;
            r_s1_last  <= last;
            r_s1_fd    <= frame_done;

            r_s2_row   <= AW'(s1_row);
            r_s2_xh    <= r_s1_xh;
            r_s2_hx    <= r_s1_hx;
            r_s2_voxel <= r_s1_voxel;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_fd    <= r_s1_fd;
        end
    end

    assign o_q_push           = r_s2_valid && !i_q_full;
    assign o_q_job.addr       = s2_addr[AW-1:0];
    assign o_q_job.voxel      = r_s2_voxel;
    assign o_q_job.first      = r_s2_first;
    assign o_q_job.last       = r_s2_last;
    assign o_q_job.frame_done = r_s2_fd;

endmodule

`default_nettype wire

### src/vbd_fifo.sv
// Short job queue between the front end and the accumulate back end.
// Depends on vbd_pkg.
`default_nettype none

module vbd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vbd_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output vbd_pkg::t_job       o_head
);

    localparam int AW = vbd_pkg::FIFO_AW;

    vbd_pkg::t_job    r_buf [vbd_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_full  = r_count == (AW+1)'(vbd_pkg::FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + AW'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wr_ptr] <= i_job;
    end

endmodule

`default_nettype wire

### src/vbd_back.sv
// Back end: read-modify-write of the partial sum store with write forwarding,
// and the result register. Depends on vbd_pkg and vbd_intf.
`default_nettype none

module vbd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire vbd_pkg::t_job  i_q_job,
    output logic                o_q_pop,
    vbd_result_if.source        o_result
);

    localparam int SW = vbd_pkg::SUM_W;
    localparam int VW = vbd_pkg::VOX_W;

    logic [SW-1:0]               r_mem [vbd_pkg::SUM_DEPTH];
    logic [SW-1:0]               r_rd_data;
    vbd_pkg::t_job               r_job;
    logic                        r_job_valid;
    logic                        r_fwd_valid;
    logic [vbd_pkg::ADDR_W-1:0]  r_fwd_addr;
    logic [SW-1:0]               r_fwd_sum;
    logic                        r_out_valid;
    logic [VW-1:0]               r_avg;
    logic                        r_fd;

    logic                        en;
    logic                        fwd_hit;
    logic [SW-1:0]               base;
    logic [SW-1:0]               sum;

    assign en      = !r_out_valid || o_result.ready;
    assign o_q_pop = en && !i_q_empty;

    // The read for the next job and the write of the current job share an
    // edge; the read sees the old entry, so the just-written sum is forwarded.
    assign fwd_hit = r_fwd_valid && (r_fwd_addr == r_job.addr);

    always_comb begin
        if (r_job.first) begin
            base = '0;
        end else if (fwd_hit) begin
            base = r_fwd_sum;
        end else begin
            base = r_rd_data;
        end
        sum = base + SW'(r_job.voxel);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_job_valid) r_mem[r_job.addr] <= sum;
            r_rd_data <= r_mem[i_q_job.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_job_valid <= o_q_pop;
            r_fwd_valid <= r_job_valid;
            r_out_valid <= r_job_valid && r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job      <= i_q_job;
            r_fwd_addr <= r_job.addr;
            r_fwd_sum  <= sum;
            r_avg      <= sum[SW-1:SW-VW];
            r_fd       <= r_job.frame_done;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.average    = r_avg;
    assign o_result.frame_done = r_fd;

endmodule

`default_nettype wire

### src/volume_4d_box_downsample.sv
// An accepted voxel passes the two address stages, a queue slot, the store read
// and the result register before its result is valid on o_result.
// Throughput: one voxel per cycle while neither the queue nor the result stalls; each kept
// voxel costs one read-modify-write of the single-port-per-direction sum store, forwarded on back-to-back hits.
// Reset: positions, time parity, queue and valids clear; sizes go to 64/64/32.
// The sum store is not cleared: a group's first voxel overwrites its entry.
`default_nettype none
`include "assert_macros.svh"

module volume_4d_box_downsample (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    vbd_voxel_if.sink     i_voxel,
    vbd_cfg_if.sink       i_cfg,
    vbd_result_if.source  o_result
);

    logic           q_push, q_pop, q_full, q_empty;
    vbd_pkg::t_job  q_in, q_head;

    vbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_voxel  (i_voxel),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in)
    );

    vbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    vbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_head),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

    `VBD_ASSERT(a_push_not_full, i_clk, i_rst_n, q_push |-> !q_full, "job pushed into full queue")
    `VBD_ASSERT(a_pop_not_empty, i_clk, i_rst_n, q_pop |-> !q_empty, "job popped from empty queue")
    `VBD_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_result.valid, "result valid after reset")

endmodule

`default_nettype wire

### test/tb_volume_4d_box_downsample.sv
// Self-checking bench for the 4D box downsampler: random voxel streams, size sweeps,
// clamped sizes and a mid-frame resize, checked beat by beat against an in-bench predictor.
// Depends on vbd_pkg, the vbd_*_if interfaces and volume_4d_box_downsample.
module tb_volume_4d_box_downsample;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [vbd_pkg::VOX_W-1:0] average;
        logic                      frame_done;
    } t_average_beat;

    logic clk;
    logic rst_n;

    vbd_voxel_if  voxel_ch ();
    vbd_result_if result_ch ();
    vbd_cfg_if    cfg_ch ();

    volume_4d_box_downsample u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_voxel  (voxel_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    // predictor state
    logic [vbd_pkg::SUM_W-1:0] group_sum [vbd_pkg::SUM_DEPTH];
    logic [vbd_pkg::CFG_W-1:0] size_reg [3];
    int unsigned               raster_x, raster_y, raster_z;
    bit                        odd_frame;

    logic [vbd_pkg::VOX_W-1:0] voxel_feed [$];
    t_average_beat             expected_averages [$];

    logic voxel_taken;
    int   tx_idle_pct, rx_idle_pct;
    int   fail_count, voxels_in, averages_checked, size_writes, random_voxels;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input logic [vbd_pkg::CFG_W-1:0] v);
        if (v < vbd_pkg::CFG_W'(2)) return 2;
        if (v > vbd_pkg::CFG_W'(vbd_pkg::MAX_DIM)) return vbd_pkg::MAX_DIM;
        return int'(v);
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("mismatch @%0t: %s", $realtime, what);
    endfunction

    // Accumulate one voxel into its group entry, queue the average on the group's last voxel.
    task automatic fold_voxel(input logic [vbd_pkg::VOX_W-1:0] v);
        int unsigned sx, sy, sz, hx, hy, hz, x, y, z, addr;
        logic [vbd_pkg::SUM_W-1:0] total;
        bit is_opening, is_closing;
        t_average_beat beat;
        sx = clamp_size(size_reg[vbd_pkg::REG_SIZE_X]);
        sy = clamp_size(size_reg[vbd_pkg::REG_SIZE_Y]);
        sz = clamp_size(size_reg[vbd_pkg::REG_SIZE_Z]);
        hx = sx >> 1;
        hy = sy >> 1;
        hz = sz >> 1;
        x = raster_x;
        y = raster_y;
        z = raster_z;
        if (x < 2 * hx && y < 2 * hy && z < 2 * hz) begin
            addr = (((z >> 1) * hy + (y >> 1)) * hx + (x >> 1)) % vbd_pkg::SUM_DEPTH;
            is_opening = ((x | y | z) & 1) == 0 && !odd_frame;
            is_closing = (x & y & z & 1) == 1 && odd_frame;
            total = is_opening ? vbd_pkg::SUM_W'(v)
                               : group_sum[addr] + vbd_pkg::SUM_W'(v);
            group_sum[addr] = total;
            if (is_closing) begin
                beat.average = total[vbd_pkg::SUM_W-1:4];
                beat.frame_done = (x == 2 * hx - 1 && y == 2 * hy - 1 && z == 2 * hz - 1);
                expected_averages.push_back(beat);
            end
        end
        if (x + 1 >= sx) begin
            raster_x = 0;
            if (y + 1 >= sy) begin
                raster_y = 0;
                if (z + 1 >= sz) begin
                    raster_z = 0;
                    odd_frame = !odd_frame;
                end else begin
                    raster_z = z + 1;
                end
            end else begin
                raster_y = y + 1;
            end
        end else begin
            raster_x = x + 1;
        end
    endtask

    // driver: new beat offered at the falling edge once the previous one is gone; result ready randomised
    always @(negedge clk) begin
        if (!rst_n) begin
            voxel_ch.valid <= 1'b0;
            result_ch.ready <= 1'b0;
        end else begin
            if (!voxel_ch.valid || voxel_taken) begin
                if (voxel_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    voxel_ch.valid <= 1'b1;
                    voxel_ch.voxel <= voxel_feed.pop_front();
                end else begin
                    voxel_ch.valid <= 1'b0;
                end
            end
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: predict on every accepted voxel, check every accepted result
    always @(posedge clk) begin
        t_average_beat want;
        if (!rst_n) begin
            voxel_taken <= 1'b0;
        end else begin
            voxel_taken <= voxel_ch.valid && voxel_ch.ready;
            if (voxel_ch.valid && voxel_ch.ready) begin
                fold_voxel(voxel_ch.voxel);
                voxels_in++;
            end
            if (result_ch.valid && result_ch.ready) begin
                averages_checked++;
                if (expected_averages.size() == 0) begin
                    note_failure($sformatf("unexpected beat average=%0d frame_done=%0b",
                        result_ch.average, result_ch.frame_done));
                end else begin
                    want = expected_averages.pop_front();
                    if (want.average !== result_ch.average
                        || want.frame_done !== result_ch.frame_done) begin
                        note_failure($sformatf(
                            "average exp %0d got %0d, frame_done exp %0b got %0b",
                            want.average, result_ch.average,
                            want.frame_done, result_ch.frame_done));
                    end
                end
            end
        end
    end

    task automatic write_size(input vbd_pkg::t_reg_idx idx,
                              input logic [vbd_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        size_reg[idx] = val;
        size_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_sizes(input logic [vbd_pkg::CFG_W-1:0] sx,
                               input logic [vbd_pkg::CFG_W-1:0] sy,
                               input logic [vbd_pkg::CFG_W-1:0] sz);
        write_size(vbd_pkg::REG_SIZE_X, sx);
        write_size(vbd_pkg::REG_SIZE_Y, sy);
        write_size(vbd_pkg::REG_SIZE_Z, sz);
    endtask

    // Biased toward the extremes so full-scale and empty groups show up.
    function automatic logic [vbd_pkg::VOX_W-1:0] pick_voxel();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return vbd_pkg::VOX_W'($urandom_range(255));
    endfunction

    task automatic queue_voxels(input int count);
        for (int i = 0; i < count; i++) voxel_feed.push_back(pick_voxel());
    endtask

    // Waits at rising edges, where the offered beat is settled, for the feed and
    // the expectations to empty, then lets the pipe settle since dropped and
    // partial voxels leave no result behind.
    task automatic wait_idle();
        do @(posedge clk);
        while (voxel_feed.size() != 0 || voxel_ch.valid || expected_averages.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random small sizes (0 and 1 act as 2), even frame count so the phase
    // ends back at the origin of an even frame.
    task automatic random_frames();
        logic [vbd_pkg::CFG_W-1:0] vx, vy, vz;
        int frames, count;
        vx = vbd_pkg::CFG_W'($urandom_range(7));
        vy = vbd_pkg::CFG_W'($urandom_range(5));
        vz = vbd_pkg::CFG_W'($urandom_range(4));
        frames = ($urandom_range(3) == 0) ? 4 : 2;
        write_sizes(vx, vy, vz);
        count = frames * clamp_size(vx) * clamp_size(vy) * clamp_size(vz);
        queue_voxels(count);
        random_voxels += count;
        wait_idle();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        voxel_ch.valid = 1'b0;
        voxel_ch.voxel = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = vbd_pkg::REG_SIZE_X;
        cfg_ch.data = '0;
        size_reg[vbd_pkg::REG_SIZE_X] = vbd_pkg::SIZE_X_RST;
        size_reg[vbd_pkg::REG_SIZE_Y] = vbd_pkg::SIZE_Y_RST;
        size_reg[vbd_pkg::REG_SIZE_Z] = vbd_pkg::SIZE_Z_RST;
        raster_x = 0;
        raster_y = 0;
        raster_z = 0;
        odd_frame = 1'b0;
        fail_count = 0;
        voxels_in = 0;
        averages_checked = 0;
        size_writes = 0;
        random_voxels = 0;
        tx_idle_pct = 34;
        rx_idle_pct = 53;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest volume: one group, all full scale, then one that truncates to zero
        write_sizes(vbd_pkg::CFG_W'(0), vbd_pkg::CFG_W'(1), vbd_pkg::CFG_W'(2));
        repeat (16) voxel_feed.push_back('1);
        voxel_feed.push_back(vbd_pkg::VOX_W'(15));
        repeat (15) voxel_feed.push_back('0);
        wait_idle();

        while (random_voxels < 150) random_frames();

        tx_idle_pct = 53;
        rx_idle_pct = 34;

        // Clamped sizes: width above MAX_DIM wraps the row at 512, height below 2
        // acts as 2. Then a 2x2x2 volume finishes the group opened by the wide row.
        write_sizes(vbd_pkg::CFG_W'(1023), vbd_pkg::CFG_W'(1), vbd_pkg::CFG_W'(0));
        queue_voxels(512);
        wait_idle();
        write_sizes(vbd_pkg::CFG_W'(2), vbd_pkg::CFG_W'(2), vbd_pkg::CFG_W'(2));
        queue_voxels(6 + 8);
        wait_idle();

        // Shrink below the current row: the rest of it is dropped, the slice
        // advances and the group opened in the larger layout completes.
        write_sizes(vbd_pkg::CFG_W'(6), vbd_pkg::CFG_W'(4), vbd_pkg::CFG_W'(4));
        queue_voxels(12);
        wait_idle();
        write_sizes(vbd_pkg::CFG_W'(2), vbd_pkg::CFG_W'(2), vbd_pkg::CFG_W'(2));
        queue_voxels(2 + 4 + 8);
        wait_idle();

        while (random_voxels < 300) random_frames();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (random_voxels < 450) random_frames();

        // unpaired final frame: only partial sums, no beats
        write_sizes(vbd_pkg::CFG_W'(5), vbd_pkg::CFG_W'(4), vbd_pkg::CFG_W'(3));
        queue_voxels(5 * 4 * 3);
        wait_idle();

        $display("%0d voxels streamed, %0d averages checked, %0d size writes",
            voxels_in, averages_checked, size_writes);
        $display("clamped sizes, odd sizes, mid-frame resize and an unpaired frame exercised");
        if (expected_averages.size() != 0) begin
            note_failure($sformatf("%0d averages never arrived", expected_averages.size()));
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("watchdog expired with %0d averages outstanding", expected_averages.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
